@@ rtl/core/bfsmf_pkg.sv @@
`default_nettype none

package bfsmf_pkg;

   localparam int CAP_W  = 31;
   localparam int FLOW_W = 40;

   localparam logic [CAP_W-1:0]  BIG_CAP  = 31'h7FFF_FFFF;
   localparam logic [FLOW_W-1:0] FLOW_MAX = 40'hFF_FFFF_FFFF;

   localparam logic [1:0] STATUS_STORED = 2'd0;
   localparam logic [1:0] STATUS_FLOW   = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // sequencer steps, one-hot
   typedef enum logic [22:0] {
      ST_INIT_CLR  = 23'd1 << 0,
      ST_IDLE      = 23'd1 << 1,
      ST_ADD_RD    = 23'd1 << 2,
      ST_ADD_WR0   = 23'd1 << 3,
      ST_ADD_WR1   = 23'd1 << 4,
      ST_SRCH_CLR  = 23'd1 << 5,
      ST_SRCH_SEED = 23'd1 << 6,
      ST_POP       = 23'd1 << 7,
      ST_POP_RD    = 23'd1 << 8,
      ST_EDGE_HEAD = 23'd1 << 9,
      ST_EDGE_CHK  = 23'd1 << 10,
      ST_EDGE_RD   = 23'd1 << 11,
      ST_EDGE_VIS  = 23'd1 << 12,
      ST_SRCH_END  = 23'd1 << 13,
      ST_AUG1_CHK  = 23'd1 << 14,
      ST_AUG1_P    = 23'd1 << 15,
      ST_AUG1_C    = 23'd1 << 16,
      ST_AUG2_CHK  = 23'd1 << 17,
      ST_AUG2_P    = 23'd1 << 18,
      ST_AUG2_W0   = 23'd1 << 19,
      ST_AUG2_W1   = 23'd1 << 20,
      ST_ADD_TOTAL = 23'd1 << 21,
      ST_FINISH    = 23'd1 << 22
   } state_type;

   typedef struct packed {
      state_type op;
      logic      accept;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic store_full;
      logic pop_done;
      logic k_end;
      logic path_ok;
      logic at_end;
      logic par_bad;
      logic bn_zero;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/bfsmf_ctrl.sv @@
`default_nettype none

module bfsmf_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_cmd,
   output logic                     req_ready,
   input  bfsmf_pkg::dp_status_type dp_status,
   output bfsmf_pkg::dp_cmd_type    dp_cmd
);

   bfsmf_pkg::state_type state_ff, state_in;

   assign req_ready     = (state_ff == bfsmf_pkg::ST_IDLE);
   assign dp_cmd.op     = state_ff;
   assign dp_cmd.accept = req_ready && req_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfsmf_pkg::ST_INIT_CLR: begin
            if (dp_status.clr_last) state_in = bfsmf_pkg::ST_IDLE;
         end
         bfsmf_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd) state_in = bfsmf_pkg::ST_SRCH_CLR;
               else if (dp_status.store_full) state_in = bfsmf_pkg::ST_FINISH;
               else state_in = bfsmf_pkg::ST_ADD_RD;
            end
         end
         bfsmf_pkg::ST_ADD_RD:    state_in = bfsmf_pkg::ST_ADD_WR0;
         bfsmf_pkg::ST_ADD_WR0:   state_in = bfsmf_pkg::ST_ADD_WR1;
         bfsmf_pkg::ST_ADD_WR1:   state_in = bfsmf_pkg::ST_FINISH;
         bfsmf_pkg::ST_SRCH_CLR: begin
            if (dp_status.clr_last) state_in = bfsmf_pkg::ST_SRCH_SEED;
         end
         bfsmf_pkg::ST_SRCH_SEED: state_in = bfsmf_pkg::ST_POP;
         bfsmf_pkg::ST_POP: begin
            state_in = dp_status.pop_done ? bfsmf_pkg::ST_SRCH_END : bfsmf_pkg::ST_POP_RD;
         end
         bfsmf_pkg::ST_POP_RD:    state_in = bfsmf_pkg::ST_EDGE_HEAD;
         bfsmf_pkg::ST_EDGE_HEAD: state_in = bfsmf_pkg::ST_EDGE_CHK;
         bfsmf_pkg::ST_EDGE_CHK: begin
            state_in = dp_status.k_end ? bfsmf_pkg::ST_POP : bfsmf_pkg::ST_EDGE_RD;
         end
         bfsmf_pkg::ST_EDGE_RD:   state_in = bfsmf_pkg::ST_EDGE_VIS;
         bfsmf_pkg::ST_EDGE_VIS:  state_in = bfsmf_pkg::ST_EDGE_CHK;
         bfsmf_pkg::ST_SRCH_END: begin
            state_in = dp_status.path_ok ? bfsmf_pkg::ST_AUG1_CHK : bfsmf_pkg::ST_FINISH;
         end
         bfsmf_pkg::ST_AUG1_CHK: begin
            state_in = dp_status.at_end ? bfsmf_pkg::ST_AUG2_CHK : bfsmf_pkg::ST_AUG1_P;
         end
         bfsmf_pkg::ST_AUG1_P: begin
            state_in = dp_status.par_bad ? bfsmf_pkg::ST_FINISH : bfsmf_pkg::ST_AUG1_C;
         end
         bfsmf_pkg::ST_AUG1_C:    state_in = bfsmf_pkg::ST_AUG1_CHK;
         bfsmf_pkg::ST_AUG2_CHK: begin
            state_in = dp_status.at_end ? bfsmf_pkg::ST_ADD_TOTAL : bfsmf_pkg::ST_AUG2_P;
         end
         bfsmf_pkg::ST_AUG2_P:    state_in = bfsmf_pkg::ST_AUG2_W0;
         bfsmf_pkg::ST_AUG2_W0:   state_in = bfsmf_pkg::ST_AUG2_W1;
         bfsmf_pkg::ST_AUG2_W1:   state_in = bfsmf_pkg::ST_AUG2_CHK;
         bfsmf_pkg::ST_ADD_TOTAL: begin
            state_in = dp_status.bn_zero ? bfsmf_pkg::ST_FINISH : bfsmf_pkg::ST_SRCH_CLR;
         end
         bfsmf_pkg::ST_FINISH: begin
            if (!dp_status.rsp_busy) state_in = bfsmf_pkg::ST_IDLE;
         end
         default: state_in = bfsmf_pkg::ST_INIT_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bfsmf_pkg::ST_INIT_CLR;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/bfsmf_dpath.sv @@
`default_nettype none

module bfsmf_dpath #(
   parameter int NODE_COUNT = 256,
   parameter int EDGE_SLOTS = 2048
) (
   input  wire                                clock,
   input  wire                                reset,
   input  bfsmf_pkg::dp_cmd_type              dp_cmd,
   output bfsmf_pkg::dp_status_type           dp_status,
   input  wire                                req_cmd,
   input  wire  [7:0]                         req_from_node,
   input  wire  [7:0]                         req_to_node,
   input  wire  [bfsmf_pkg::CAP_W-1:0]        req_edge_capacity,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [bfsmf_pkg::FLOW_W-1:0]       rsp_flow_total
);

   localparam int NW = $clog2(NODE_COUNT);
   localparam int SW = $clog2(EDGE_SLOTS);
   localparam int EW = SW + 1;
   localparam int QW = NW + 1;
   localparam int CW = bfsmf_pkg::CAP_W;
   localparam int FW = bfsmf_pkg::FLOW_W;
   localparam logic [EW-1:0] NO_EDGE  = EW'(EDGE_SLOTS);
   localparam logic [QW-1:0] NODE_LIM = QW'(NODE_COUNT);
   localparam logic [NW-1:0] NODE_TOP = NW'(NODE_COUNT - 1);

   // reduce a raw node number modulo NODE_COUNT by restoring subtraction
   function automatic logic [NW-1:0] node_of(input logic [7:0] raw);
      int r;
      r = int'(raw);
      for (int i = 7; i >= 0; i--) begin
         if (r >= (NODE_COUNT << i)) r = r - (NODE_COUNT << i);
      end
      return NW'(r);
   endfunction

   // stores
   logic [CW-1:0] cap_mem    [EDGE_SLOTS];
   logic [NW-1:0] target_mem [EDGE_SLOTS];
   logic [EW-1:0] next_mem   [EDGE_SLOTS];
   logic [EW-1:0] head_mem   [NODE_COUNT];
   logic          visit_mem  [NODE_COUNT];
   logic [EW-1:0] parent_mem [NODE_COUNT];
   logic [NW-1:0] queue_mem  [NODE_COUNT];

   // registered read data
   logic [CW-1:0] cap_a_ff, cap_b_ff;
   logic [NW-1:0] target_rd_ff;
   logic [EW-1:0] next_rd_ff;
   logic [EW-1:0] head_a_ff, head_b_ff;
   logic          visit_rd_ff;
   logic [EW-1:0] parent_rd_ff;
   logic [NW-1:0] queue_rd_ff;

   // working registers
   logic [NW-1:0] a_ff, a_in, b_ff, b_in, v_ff, v_in, clr_ff, clr_in;
   logic [CW-1:0] cap_ff, cap_in, bn_ff, bn_in;
   logic [EW-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [QW-1:0] qhead_ff, qhead_in, qtail_ff, qtail_in, steps_ff, steps_in;
   logic          found_ff, found_in;
   logic [FW-1:0] total_ff, total_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [FW-1:0] rsp_flow_ff, rsp_flow_in;

   // memory controls
   logic          cap_we, cap_re, link_we, link_re, head_we, head_re;
   logic          vis_we, vis_wd, vis_re, par_we, par_re, queue_we, queue_re;
   logic [SW-1:0] cap_wa, cap_ra_a, cap_ra_b, link_wa, link_ra;
   logic [CW-1:0] cap_wd;
   logic [NW-1:0] tgt_wd, head_wa, head_ra_a, head_ra_b, vis_wa, vis_ra;
   logic [NW-1:0] par_wa, par_ra, queue_wa, queue_ra, queue_wd;
   logic [EW-1:0] nxt_wd, head_wd, par_wd;

   logic [SW-1:0] k_idx, k_pair, par_idx, par_pair;
   logic [EW-1:0] cnt_p1;
   logic          take;
   logic [FW:0]   total_sum;

   assign k_idx    = k_ff[SW-1:0];
   assign k_pair   = k_idx ^ SW'(1);
   assign par_idx  = parent_rd_ff[SW-1:0];
   assign par_pair = par_idx ^ SW'(1);
   assign cnt_p1   = cnt_ff + EW'(1);
   assign take     = !visit_rd_ff && (cap_a_ff != '0);
   assign total_sum = {1'b0, total_ff} + (FW + 1)'(bn_ff);

   assign dp_status.clr_last   = (clr_ff == NODE_TOP);
   assign dp_status.store_full = ((EW + 1)'(cnt_ff) + (EW + 1)'(2)) > (EW + 1)'(EDGE_SLOTS);
   assign dp_status.pop_done   = !(qhead_ff < qtail_ff) || found_ff;
   assign dp_status.k_end      = (k_ff >= NO_EDGE);
   assign dp_status.path_ok    = found_ff && (a_ff != b_ff);
   assign dp_status.at_end     = (v_ff == a_ff) || (steps_ff == NODE_LIM);
   assign dp_status.par_bad    = (parent_rd_ff >= NO_EDGE);
   assign dp_status.bn_zero    = (bn_ff == '0);
   assign dp_status.rsp_busy   = rsp_valid_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_flow_total = rsp_flow_ff;

   always_comb begin
      cap_we = 1'b0; cap_re = 1'b0; link_we = 1'b0; link_re = 1'b0;
      head_we = 1'b0; head_re = 1'b0; vis_we = 1'b0; vis_wd = 1'b0; vis_re = 1'b0;
      par_we = 1'b0; par_re = 1'b0; queue_we = 1'b0; queue_re = 1'b0;
      cap_wa = '0; cap_ra_a = '0; cap_ra_b = '0; link_wa = '0; link_ra = '0;
      cap_wd = '0; tgt_wd = '0; nxt_wd = '0;
      head_wa = '0; head_wd = '0; head_ra_a = a_ff; head_ra_b = b_ff;
      vis_wa = '0; vis_ra = '0; par_wa = '0; par_wd = '0; par_ra = v_ff;
      queue_wa = '0; queue_wd = '0; queue_ra = '0;
      case (dp_cmd.op)
         bfsmf_pkg::ST_INIT_CLR: begin
            head_we = 1'b1; head_wa = clr_ff; head_wd = NO_EDGE;
         end
         bfsmf_pkg::ST_ADD_RD: head_re = 1'b1;
         bfsmf_pkg::ST_ADD_WR0: begin
            cap_we = 1'b1; cap_wa = cnt_ff[SW-1:0]; cap_wd = cap_ff;
            link_we = 1'b1; link_wa = cnt_ff[SW-1:0]; tgt_wd = b_ff; nxt_wd = head_a_ff;
            head_we = 1'b1; head_wa = a_ff; head_wd = cnt_ff;
         end
         bfsmf_pkg::ST_ADD_WR1: begin
            cap_we = 1'b1; cap_wa = cnt_p1[SW-1:0]; cap_wd = '0;
            link_we = 1'b1; link_wa = cnt_p1[SW-1:0]; tgt_wd = a_ff;
            // a self loop puts its reverse slot ahead of the forward one in the list
            nxt_wd = (a_ff == b_ff) ? cnt_ff : head_b_ff;
            head_we = 1'b1; head_wa = b_ff; head_wd = cnt_p1;
         end
         bfsmf_pkg::ST_SRCH_CLR: begin
            vis_we = 1'b1; vis_wa = clr_ff; vis_wd = 1'b0;
         end
         bfsmf_pkg::ST_SRCH_SEED: begin
            vis_we = 1'b1; vis_wa = a_ff; vis_wd = 1'b1;
            queue_we = 1'b1; queue_wa = '0; queue_wd = a_ff;
         end
         bfsmf_pkg::ST_POP: begin
            queue_re = !dp_status.pop_done; queue_ra = qhead_ff[NW-1:0];
         end
         bfsmf_pkg::ST_POP_RD: begin
            head_re = 1'b1; head_ra_a = queue_rd_ff;
         end
         bfsmf_pkg::ST_EDGE_CHK: begin
            link_re = !dp_status.k_end; link_ra = k_idx;
            cap_re = !dp_status.k_end; cap_ra_a = k_idx; cap_ra_b = k_pair;
         end
         bfsmf_pkg::ST_EDGE_RD: begin
            vis_re = 1'b1; vis_ra = target_rd_ff;
         end
         bfsmf_pkg::ST_EDGE_VIS: begin
            vis_we = take; vis_wa = target_rd_ff; vis_wd = 1'b1;
            par_we = take; par_wa = target_rd_ff; par_wd = k_ff;
            queue_we = take && (qtail_ff < NODE_LIM);
            queue_wa = qtail_ff[NW-1:0]; queue_wd = target_rd_ff;
         end
         bfsmf_pkg::ST_AUG1_CHK, bfsmf_pkg::ST_AUG2_CHK: par_re = !dp_status.at_end;
         bfsmf_pkg::ST_AUG1_P, bfsmf_pkg::ST_AUG2_P: begin
            cap_re = !dp_status.par_bad; cap_ra_a = par_idx; cap_ra_b = par_pair;
            link_re = !dp_status.par_bad; link_ra = par_pair;
         end
         bfsmf_pkg::ST_AUG2_W0: begin
            cap_we = 1'b1; cap_wa = k_idx; cap_wd = cap_a_ff - bn_ff;
         end
         bfsmf_pkg::ST_AUG2_W1: begin
            cap_we = 1'b1; cap_wa = k_pair; cap_wd = cap_b_ff + bn_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; v_in = v_ff; clr_in = clr_ff;
      cap_in = cap_ff; bn_in = bn_ff; cnt_in = cnt_ff; k_in = k_ff;
      qhead_in = qhead_ff; qtail_in = qtail_ff; steps_in = steps_ff;
      found_in = found_ff; total_in = total_ff; res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff; rsp_flow_in = rsp_flow_ff;
      case (dp_cmd.op)
         bfsmf_pkg::ST_INIT_CLR, bfsmf_pkg::ST_SRCH_CLR: begin
            clr_in = dp_status.clr_last ? '0 : clr_ff + NW'(1);
         end
         bfsmf_pkg::ST_IDLE: begin
            if (dp_cmd.accept) begin
               a_in = node_of(req_from_node);
               b_in = node_of(req_to_node);
               cap_in = req_edge_capacity;
               total_in = '0;
               if (req_cmd) res_status_in = bfsmf_pkg::STATUS_FLOW;
               else if (dp_status.store_full) res_status_in = bfsmf_pkg::STATUS_FULL;
               else res_status_in = bfsmf_pkg::STATUS_STORED;
            end
         end
         bfsmf_pkg::ST_ADD_WR1: cnt_in = cnt_ff + EW'(2);
         bfsmf_pkg::ST_SRCH_SEED: begin
            qhead_in = '0; qtail_in = QW'(1); found_in = (a_ff == b_ff);
         end
         bfsmf_pkg::ST_POP: begin
            if (!dp_status.pop_done) qhead_in = qhead_ff + QW'(1);
         end
         bfsmf_pkg::ST_EDGE_HEAD: k_in = head_a_ff;
         bfsmf_pkg::ST_EDGE_VIS: begin
            if (take) begin
               if (qtail_ff < NODE_LIM) qtail_in = qtail_ff + QW'(1);
               if (target_rd_ff == b_ff) found_in = 1'b1;
            end
            k_in = next_rd_ff;
         end
         bfsmf_pkg::ST_SRCH_END: begin
            v_in = b_ff; bn_in = bfsmf_pkg::BIG_CAP; steps_in = '0;
         end
         bfsmf_pkg::ST_AUG1_CHK: begin
            if (dp_status.at_end) begin
               v_in = b_ff; steps_in = '0;
            end
         end
         bfsmf_pkg::ST_AUG1_P, bfsmf_pkg::ST_AUG2_P: k_in = parent_rd_ff;
         bfsmf_pkg::ST_AUG1_C: begin
            if (cap_a_ff < bn_ff) bn_in = cap_a_ff;
            v_in = target_rd_ff; steps_in = steps_ff + QW'(1);
         end
         bfsmf_pkg::ST_AUG2_W1: begin
            v_in = target_rd_ff; steps_in = steps_ff + QW'(1);
         end
         bfsmf_pkg::ST_ADD_TOTAL: begin
            if (!dp_status.bn_zero) begin
               total_in = total_sum[FW] ? bfsmf_pkg::FLOW_MAX : total_sum[FW-1:0];
            end
         end
         bfsmf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_flow_in = total_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_wa] <= cap_wd;
      if (cap_re) begin
         cap_a_ff <= cap_mem[cap_ra_a];
         cap_b_ff <= cap_mem[cap_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         target_mem[link_wa] <= tgt_wd;
         next_mem[link_wa] <= nxt_wd;
      end
      if (link_re) begin
         target_rd_ff <= target_mem[link_ra];
         next_rd_ff <= next_mem[link_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (head_re) begin
         head_a_ff <= head_mem[head_ra_a];
         head_b_ff <= head_mem[head_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) visit_mem[vis_wa] <= vis_wd;
      if (vis_re) visit_rd_ff <= visit_mem[vis_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) parent_mem[par_wa] <= par_wd;
      if (par_re) parent_rd_ff <= parent_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      if (queue_re) queue_rd_ff <= queue_mem[queue_ra];
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; v_ff <= v_in; cap_ff <= cap_in; bn_ff <= bn_in;
      k_ff <= k_in; steps_ff <= steps_in; total_ff <= total_in;
      res_status_ff <= res_status_in; rsp_status_ff <= rsp_status_in;
      rsp_flow_ff <= rsp_flow_in;
      if (reset) begin
         clr_ff <= '0; cnt_ff <= '0; qhead_ff <= '0; qtail_ff <= '0;
         found_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in; cnt_ff <= cnt_in; qhead_ff <= qhead_in; qtail_ff <= qtail_in;
         found_ff <= found_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cnt_even: assert property (@(posedge clock) disable iff (reset) !cnt_ff[0])
      else $error("edge count odd");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NO_EDGE)
      else $error("edge count beyond slot store");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (qhead_ff <= qtail_ff) && (qtail_ff <= NODE_LIM))
      else $error("search queue pointers out of order");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == bfsmf_pkg::ST_FINISH) && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("result not loaded on finish");

endmodule

`default_nettype wire

@@ rtl/core/bfs_augmenting_max_flow_core.sv @@
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_cmd, req_from_node, req_to_node,
//                                          req_edge_capacity
// rsp      out        rsp_valid/rsp_ready  rsp_status, rsp_flow_total
//
// An add-edge item reads both heads and writes its two slots before the result is raised;
// a full store skips to the finish step. Each search of a run clears the visited marks,
// dequeues nodes and scans their edges, then walks each path found once for its bottleneck
// and once to update capacities. No item is taken before the head store clear after reset.
// One item may be taken while a result still waits; its own result then holds in the
// finish step until the waiting one drains.

module bfs_augmenting_max_flow_core #(
   parameter int NODE_COUNT = 256,
   parameter int EDGE_SLOTS = 2048
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           req_cmd,
   input  wire  [7:0]                    req_from_node,
   input  wire  [7:0]                    req_to_node,
   input  wire  [bfsmf_pkg::CAP_W-1:0]   req_edge_capacity,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [bfsmf_pkg::FLOW_W-1:0]  rsp_flow_total
);

   // sequencer commands down, datapath flags up
   bfsmf_pkg::dp_cmd_type    dp_cmd;
   bfsmf_pkg::dp_status_type dp_status;

   bfsmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // edge store, adjacency heads, search queue and augmenting walk
   bfsmf_dpath #(
      .NODE_COUNT (NODE_COUNT),
      .EDGE_SLOTS (EDGE_SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_cmd           (req_cmd),
      .req_from_node     (req_from_node),
      .req_to_node       (req_to_node),
      .req_edge_capacity (req_edge_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_flow_total    (rsp_flow_total)
   );

endmodule

`default_nettype wire

@@ test/bfs_augmenting_max_flow_core_test.sv @@
`timescale 1ns / 1ps

module bfs_augmenting_max_flow_core_test;

   localparam int NODES       = 256;
   localparam int SLOTS       = 2048;
   localparam logic [11:0] NO_EDGE = 12'(SLOTS);
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_RUN   = 1'b1;
   localparam int WINDOWS     = 31;      // 8-node islands, nodes 0..247
   localparam int RANDOM_ITEMS = 1217;
   localparam int PARALLEL_EDGES = 513;  // enough saturated edges to overflow the total
   localparam longint CYCLE_LIMIT = 40_000_000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_cmd;
   logic [7:0]                     req_from_node;
   logic [7:0]                     req_to_node;
   logic [bfsmf_pkg::CAP_W-1:0]    req_edge_capacity;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [1:0]                     rsp_status;
   logic [bfsmf_pkg::FLOW_W-1:0]   rsp_flow_total;

   bfs_augmenting_max_flow_core #(
      .NODE_COUNT (NODES),
      .EDGE_SLOTS (SLOTS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_from_node     (req_from_node),
      .req_to_node       (req_to_node),
      .req_edge_capacity (req_edge_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_flow_total    (rsp_flow_total)
   );

   // Own copy of the graph: residual capacities, links and search scratch
   logic [31:0] residual [SLOTS];
   logic [7:0]  edge_head_node [SLOTS];
   logic [11:0] edge_link [SLOTS];
   logic [11:0] first_edge [NODES];
   int unsigned slots_used;
   bit          reached [NODES];
   logic [11:0] came_by [NODES];
   logic [7:0]  frontier [NODES];

   typedef struct {
      logic [1:0]                   status;
      logic [bfsmf_pkg::FLOW_W-1:0] flow;
   } outcome_t;

   outcome_t pending_outcomes[$];

   typedef struct {
      logic                         cmd;
      logic [7:0]                   from_node;
      logic [7:0]                   to_node;
      logic [bfsmf_pkg::CAP_W-1:0]  cap;
      bit                           typed;
      logic [1:0]                   status;
      logic [bfsmf_pkg::FLOW_W-1:0] flow;
   } stim_row_t;

   int  errors;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  recv_hold;
   longint cycles = 0;

   // Breadth-first search over edges with residual capacity left
   function automatic bit route_exists(input logic [7:0] src, input logic [7:0] dst);
      int unsigned qh, qt;
      logic [7:0]  u, v;
      logic [11:0] k;
      qh = 0;
      qt = 0;
      for (int n = 0; n < NODES; n++) begin
         reached[n] = 1'b0;
         came_by[n] = NO_EDGE;
      end
      reached[src] = 1'b1;
      frontier[qt] = src;
      qt++;
      while (qh < qt && !reached[dst]) begin
         u = frontier[qh];
         qh++;
         k = first_edge[u];
         while (k < SLOTS) begin
            v = edge_head_node[k];
            if (!reached[v] && residual[k] != 0) begin
               reached[v] = 1'b1;
               came_by[v] = k;
               if (qt < NODES) begin
                  frontier[qt] = v;
                  qt++;
               end
            end
            k = edge_link[k];
         end
      end
      return reached[dst] && (src != dst);
   endfunction

   // Push the bottleneck along the found path; returns it
   function automatic logic [31:0] push_flow(input logic [7:0] src, input logic [7:0] dst);
      logic [31:0] neck;
      logic [7:0]  v;
      logic [11:0] k;
      int          steps;
      neck = 32'(bfsmf_pkg::BIG_CAP);
      v = dst;
      for (steps = 0; v != src && steps < NODES; steps++) begin
         k = came_by[v];
         if (k >= SLOTS) return 32'd0;
         if (residual[k] < neck) neck = residual[k];
         v = edge_head_node[k ^ 12'd1];
      end
      v = dst;
      for (steps = 0; v != src && steps < NODES; steps++) begin
         k = came_by[v];
         residual[k] = residual[k] - neck;
         residual[k ^ 12'd1] = residual[k ^ 12'd1] + neck;
         v = edge_head_node[k ^ 12'd1];
      end
      return neck;
   endfunction

   function automatic outcome_t predict_outcome(input logic cmd, input logic [7:0] a,
                                                input logic [7:0] b,
                                                input logic [bfsmf_pkg::CAP_W-1:0] cap);
      outcome_t        o;
      longint unsigned total;
      logic [31:0]     f;
      o.flow = '0;
      if (cmd == CMD_ADD) begin
         if (slots_used + 2 > SLOTS) begin
            o.status = bfsmf_pkg::STATUS_FULL;
            return o;
         end
         residual[slots_used]       = {1'b0, cap};
         edge_head_node[slots_used] = b;
         edge_link[slots_used]      = first_edge[a];
         first_edge[a]              = 12'(slots_used);
         residual[slots_used+1]       = 32'd0;
         edge_head_node[slots_used+1] = a;
         edge_link[slots_used+1]      = first_edge[b];
         first_edge[b]                = 12'(slots_used + 1);
         slots_used += 2;
         o.status = bfsmf_pkg::STATUS_STORED;
         return o;
      end
      total = 0;
      while (route_exists(a, b)) begin
         f = push_flow(a, b);
         if (f == 0) break;
         total += f;
         if (total > bfsmf_pkg::FLOW_MAX) total = bfsmf_pkg::FLOW_MAX;
      end
      o.status = bfsmf_pkg::STATUS_FLOW;
      o.flow   = total[bfsmf_pkg::FLOW_W-1:0];
      return o;
   endfunction

   // Offer one item, hold it until taken, then file its expected outcome
   task automatic offer_item(input stim_row_t r);
      outcome_t o;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= r.cmd;
      req_from_node     <= r.from_node;
      req_to_node       <= r.to_node;
      req_edge_capacity <= r.cap;
      do @(posedge clock); while (!(req_valid && req_ready));
      o = predict_outcome(r.cmd, r.from_node, r.to_node, r.cap);
      if (r.typed) begin
         o.status = r.status;
         o.flow   = r.flow;
      end
      pending_outcomes.push_back(o);
   endtask

   function automatic stim_row_t plain_row(input logic cmd, input int a, input int b,
                                           input logic [bfsmf_pkg::CAP_W-1:0] cap);
      stim_row_t r;
      r.cmd = cmd;
      r.from_node = 8'(a);
      r.to_node = 8'(b);
      r.cap = cap;
      r.typed = 1'b0;
      r.status = '0;
      r.flow = '0;
      return r;
   endfunction

   // Mostly adds and runs inside one island, now and then a cross-island edge
   function automatic stim_row_t random_row();
      stim_row_t r;
      int        base;
      int        pick;
      base = $urandom_range(WINDOWS - 1) * 8;
      r = plain_row(CMD_ADD, base + $urandom_range(7), base + $urandom_range(7), '0);
      pick = $urandom_range(99);
      if (pick < 3) begin
         r.from_node = 8'($urandom_range(WINDOWS * 8 - 1));
         r.to_node   = 8'($urandom_range(WINDOWS * 8 - 1));
      end
      if ($urandom_range(99) < 22) begin
         r.cmd = CMD_RUN;
         if ($urandom_range(19) == 0) r.to_node = r.from_node;
      end
      case ($urandom_range(7))
         0:       r.cap = bfsmf_pkg::BIG_CAP;
         1:       r.cap = '0;
         2, 3:    r.cap = bfsmf_pkg::CAP_W'($urandom_range(20, 1));
         default: r.cap = bfsmf_pkg::CAP_W'($urandom);
      endcase
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: check each taken item, then pick the next ready level
   initial begin
      outcome_t want;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result with nothing expected: status %0d flow %0d",
                      rsp_status, rsp_flow_total);
               errors++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_flow_total !== want.flow) begin
                  $error("flow_total: expected %0d, got %0d", want.flow, rsp_flow_total);
                  errors++;
               end
            end
         end
         // a long hold-off lets the block fill up and stall its input
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      stim_row_t directed [$];
      stim_row_t r;
      int        wait_cycles;

      errors = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 0;
      slots_used = 0;
      for (int n = 0; n < NODES; n++) begin
         first_edge[n] = NO_EDGE;
         came_by[n] = NO_EDGE;
      end

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_cmd           <= CMD_ADD;
      req_from_node     <= '0;
      req_to_node       <= '0;
      req_edge_capacity <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty graph, source equals sink, zero and full capacity,
      // parallel edges, a chain with a shortcut, a back edge, no forward path
      r = plain_row(CMD_RUN, 248, 249, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = '0;
      directed.push_back(r);
      r = plain_row(CMD_RUN, 255, 255, bfsmf_pkg::BIG_CAP);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = '0;
      directed.push_back(r);
      r = plain_row(CMD_ADD, 248, 249, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_STORED; r.flow = '0;
      directed.push_back(r);
      r = plain_row(CMD_RUN, 248, 249, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = '0;
      directed.push_back(r);
      r = plain_row(CMD_ADD, 248, 249, bfsmf_pkg::BIG_CAP);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_STORED; r.flow = '0;
      directed.push_back(r);
      r = plain_row(CMD_RUN, 248, 249, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW;
      r.flow = bfsmf_pkg::FLOW_W'(bfsmf_pkg::BIG_CAP);
      directed.push_back(r);
      directed.push_back(plain_row(CMD_ADD, 248, 249, 5));
      directed.push_back(plain_row(CMD_ADD, 248, 249, 7));
      r = plain_row(CMD_RUN, 248, 249, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = 40'd12;
      directed.push_back(r);
      directed.push_back(plain_row(CMD_ADD, 249, 250, 3));
      directed.push_back(plain_row(CMD_ADD, 250, 251, 100));
      directed.push_back(plain_row(CMD_ADD, 249, 251, 1));
      directed.push_back(plain_row(CMD_RUN, 248, 251, '0));
      directed.push_back(plain_row(CMD_ADD, 251, 248, 1));
      directed.push_back(plain_row(CMD_RUN, 251, 249, '0));
      directed.push_back(plain_row(CMD_ADD, 253, 252, 1));
      r = plain_row(CMD_RUN, 252, 253, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = '0;
      directed.push_back(r);
      directed.push_back(plain_row(CMD_ADD, 0, 255, 9));
      directed.push_back(plain_row(CMD_RUN, 255, 0, '0));

      send_idle_pct = 20;
      recv_idle_pct = 50;
      foreach (directed[i]) offer_item(directed[i]);

      // Enough saturated parallel edges that the run total overflows
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < PARALLEL_EDGES; i++)
         offer_item(plain_row(CMD_ADD, 254, 255, bfsmf_pkg::BIG_CAP));
      r = plain_row(CMD_RUN, 254, 255, '0);
      r.typed = 1'b1; r.status = bfsmf_pkg::STATUS_FLOW; r.flow = bfsmf_pkg::FLOW_MAX;
      offer_item(r);

      // Random islands; the store fills part way through, so later adds are refused
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 0) begin
            send_idle_pct = 20;
            recv_idle_pct = 82;
            recv_hold = 3000;
         end else if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 82;
            recv_idle_pct = 20;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         offer_item(random_row());
      end
      req_valid <= 1'b0;

      // drain, then allow for a late stray result
      wait_cycles = 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      while (wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end

      if (pending_outcomes.size() != 0) begin
         $error("%0d expected results never arrived", pending_outcomes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/bfsmf_pkg.sv
rtl/core/bfsmf_ctrl.sv
rtl/core/bfsmf_dpath.sv
rtl/core/bfs_augmenting_max_flow_core.sv
test/bfs_augmenting_max_flow_core_test.sv
